@@ src/assert_macros.svh @@
// Assertion helpers used by the logger top RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition implies a consequence in the following cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/ttlog_pkg.sv @@
`default_nettype none

package ttlog_pkg;

  // Input command codes
  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_BYTE   = 2'd1;
  localparam logic [1:0] CMD_COMMIT = 2'd2;
  localparam logic [1:0] CMD_DUMP   = 2'd3;

  // Digit entry modes
  localparam logic [1:0] MODE_NONE   = 2'd0;
  localparam logic [1:0] MODE_PERIOD = 2'd1;
  localparam logic [1:0] MODE_CLOCK  = 2'd2;

  // Result kinds
  localparam logic KIND_ECHO  = 1'b0;
  localparam logic KIND_ENTRY = 1'b1;

  // Serial characters
  localparam logic [7:0] CHAR_D    = 8'h64;
  localparam logic [7:0] CHAR_G    = 8'h67;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_ZERO = 8'h30;

  // Time base
  localparam logic [9:0]  MS_LAST      = 10'd999;
  localparam logic [41:0] MS_PER_SEC   = 42'd1000;
  localparam logic [41:0] PERIOD_RESET = 42'd1000;

  // Conversion constants: degrees = trunc((raw*2500 - 254976) / 5120)
  localparam logic [21:0]        CONV_GAIN   = 22'd2500;
  localparam logic signed [22:0] CONV_OFFSET = 23'sd254976;
  localparam logic [27:0]        RECIP_FIVE  = 28'd52429;

  typedef struct packed {
    logic [31:0]        seconds;
    logic signed [9:0]  temp;
  } log_entry_t;

  typedef struct packed {
    logic        neg;
    logic [11:0] mag;
  } conv_part_t;

  // First conversion step: scale, remove offset, take magnitude / 1024.
  function automatic conv_part_t conv_start(input logic [9:0] raw);
    logic [21:0]        prod;
    logic signed [22:0] num;
    logic [22:0]        mag;
    conv_part_t         res;
    prod = 22'(raw) * CONV_GAIN;
    num = $signed({1'b0, prod}) - CONV_OFFSET;
    mag = num[22] ? 23'(-num) : 23'(num);
    res.neg = num[22];
    res.mag = mag[21:10];
    return res;
  endfunction

  // Second conversion step: divide by five through the reciprocal, restore sign.
  function automatic logic signed [9:0] conv_finish(input conv_part_t part);
    logic [27:0] prod;
    logic [9:0]  q;
    prod = 28'(part.mag) * RECIP_FIVE;
    q = prod[27:18];
    return part.neg ? $signed(10'(-q)) : $signed(q);
  endfunction

endpackage

`default_nettype wire

@@ src/ttlog_ram.sv @@
`default_nettype none

module ttlog_ram #(
  parameter int WIDTH = 42,
  parameter int DEPTH = 64
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ src/timestamped_temperature_logger_top.sv @@
// Timestamped temperature logger.
// Input channel (in_valid/in_ready): command with sample and rx_byte. A tick
// advances the millisecond uptime and, when the sampling period has run out and
// the log is not full, converts sample to degrees and logs it with the uptime in
// seconds. A serial byte is echoed and feeds the mode/digit entry; commit applies
// the digits as period or clock; dump sends every log entry, oldest first, and
// empties the log.
// Output channel (out_valid/out_ready): one registered result slot.
// A tick without a sample and a period commit are handled in the idle state; a
// tick that logs passes two conversion stages, CONV_A and then CONV_B, which
// writes the log. An echo shows up the cycle after its transaction. A clock
// commit walks the log through the single-port-read log memory. A dump reads
// each entry in DUMP_RD and loads it into the free output slot in DUMP_LD.
// Input is taken only outside reset, when no command is in progress and the output
// slot is free or being emptied, so a receiver stall holds both the result and the
// input side.
// Reset (synchronous) empties the log, clears uptime and digits, and sets the
// period to 1000 ms; the log memory itself is not cleared.
`default_nettype none

`include "assert_macros.svh"

module timestamped_temperature_logger_top #(
  parameter int LOG_DEPTH  = 64,
  parameter int MAX_DIGITS = 10
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        command,
  input  wire logic [9:0]        sample,
  input  wire logic [7:0]        rx_byte,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   kind,
  output logic [7:0]             echo_byte,
  output logic [31:0]            entry_seconds,
  output logic signed [9:0]      entry_temp,
  output logic                   last
);

  localparam int AW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int CW = $clog2(LOG_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(LOG_DEPTH);
  localparam logic [3:0] DIGIT_LIMIT = 4'(MAX_DIGITS);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_CONV_A  = 3'd1;
  localparam logic [2:0] ST_CONV_B  = 3'd2;
  localparam logic [2:0] ST_COMMIT  = 3'd3;
  localparam logic [2:0] ST_DUMP_RD = 3'd4;
  localparam logic [2:0] ST_DUMP_LD = 3'd5;

  logic [2:0]    state;
  logic [CW-1:0] fill_count;
  logic [31:0]   ms_since_sample;
  logic [31:0]   uptime_sec;
  logic [9:0]    uptime_frac;
  logic [41:0]   period_ms;
  logic [31:0]   digit_value;
  logic [3:0]    digit_count;
  logic [1:0]    entry_mode;
  logic [CW-1:0] idx;
  logic          rd_pend;
  logic [AW-1:0] rd_idx;
  logic [31:0]   offset;
  logic [9:0]    pend_raw;
  logic [31:0]   pend_secs;
  ttlog_pkg::conv_part_t conv_part;

  logic          in_accept;
  logic          out_free;
  logic [31:0]   sec_next;
  logic [31:0]   since_next;
  logic          sample_due;
  logic          digit_wrap;
  logic [31:0]   digit_base;
  logic [7:0]    digit;
  logic [CW-1:0] idx_inc;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  ttlog_pkg::log_entry_t ram_wdata;
  ttlog_pkg::log_entry_t ram_rdata;

  // Handshake
  assign out_free  = !out_valid || out_ready;
  assign in_ready  = !rst && (state == ST_IDLE) && out_free;
  assign in_accept = in_valid && in_ready;

  // Tick arithmetic
  assign sec_next   = uptime_sec + 32'(uptime_frac == ttlog_pkg::MS_LAST);
  assign since_next = ms_since_sample + 32'd1;
  assign sample_due = period_ms <= {10'd0, since_next};

  // Digit accumulation
  assign digit_wrap = digit_count >= DIGIT_LIMIT;
  assign digit_base = digit_wrap ? 32'd0 : digit_value;
  assign digit      = rx_byte - ttlog_pkg::CHAR_ZERO;

  assign idx_inc = idx + CW'(1);

  // Log memory write source: new sample or clock shift write-back
  always_comb begin
    ram_we            = 1'b0;
    ram_waddr         = fill_count[AW-1:0];
    ram_wdata.seconds = pend_secs;
    ram_wdata.temp    = ttlog_pkg::conv_finish(conv_part);
    if (state == ST_CONV_B) begin
      ram_we = 1'b1;
    end else if (state == ST_COMMIT && rd_pend) begin
      ram_we            = 1'b1;
      ram_waddr         = rd_idx;
      ram_wdata.temp    = ram_rdata.temp;
      ram_wdata.seconds = (ram_rdata.seconds != 32'd0) ?
                          ram_rdata.seconds + offset : ram_rdata.seconds;
    end
  end

  ttlog_ram #(
    .WIDTH($bits(ttlog_pkg::log_entry_t)),
    .DEPTH(LOG_DEPTH)
  ) u_log_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(idx[AW-1:0]),
    .rdata(ram_rdata)
  );

  // Payload registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_accept && command == ttlog_pkg::CMD_TICK) begin
      pend_raw  <= sample;
      pend_secs <= sec_next;
    end
    if (state == ST_CONV_A) begin
      conv_part <= ttlog_pkg::conv_start(pend_raw);
    end
    if (state == ST_IDLE && in_accept && command == ttlog_pkg::CMD_COMMIT) begin
      offset <= digit_value - uptime_sec;
    end
    if (state == ST_COMMIT) begin
      rd_idx <= idx[AW-1:0];
    end
  end

  // Control, counters and output slot
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      fill_count      <= '0;
      ms_since_sample <= '0;
      uptime_sec      <= '0;
      uptime_frac     <= '0;
      period_ms       <= ttlog_pkg::PERIOD_RESET;
      digit_value     <= '0;
      digit_count     <= '0;
      entry_mode      <= ttlog_pkg::MODE_NONE;
      idx             <= '0;
      rd_pend         <= 1'b0;
      out_valid       <= 1'b0;
      kind            <= 1'b0;
      echo_byte       <= '0;
      entry_seconds   <= '0;
      entry_temp      <= '0;
      last            <= 1'b0;
    end else begin
      // Drop the result once taken
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_accept) begin
            unique case (command)
              ttlog_pkg::CMD_TICK: begin
                uptime_sec  <= sec_next;
                uptime_frac <= (uptime_frac == ttlog_pkg::MS_LAST) ?
                               10'd0 : uptime_frac + 10'd1;
                if (sample_due) begin
                  ms_since_sample <= '0;
                  if (fill_count < FULL) begin
                    state <= ST_CONV_A;
                  end
                end else begin
                  ms_since_sample <= since_next;
                end
              end
              ttlog_pkg::CMD_BYTE: begin
                out_valid     <= 1'b1;
                kind          <= ttlog_pkg::KIND_ECHO;
                echo_byte     <= rx_byte;
                entry_seconds <= '0;
                entry_temp    <= '0;
                last          <= 1'b1;
                if (rx_byte == ttlog_pkg::CHAR_D) begin
                  entry_mode <= ttlog_pkg::MODE_PERIOD;
                end else if (rx_byte == ttlog_pkg::CHAR_G) begin
                  entry_mode <= ttlog_pkg::MODE_CLOCK;
                end else if (rx_byte != ttlog_pkg::CHAR_LF &&
                             rx_byte != ttlog_pkg::CHAR_CR) begin
                  digit_value <= {digit_base[28:0], 3'b000} + {digit_base[30:0], 1'b0}
                                 + 32'(digit);
                  digit_count <= (digit_wrap ? 4'd0 : digit_count) + 4'd1;
                end
              end
              ttlog_pkg::CMD_COMMIT: begin
                if (entry_mode == ttlog_pkg::MODE_CLOCK) begin
                  uptime_sec  <= digit_value;
                  uptime_frac <= '0;
                  idx         <= '0;
                  rd_pend     <= 1'b0;
                  state       <= ST_COMMIT;
                end else if (entry_mode == ttlog_pkg::MODE_PERIOD) begin
                  period_ms <= 42'(42'(digit_value) * ttlog_pkg::MS_PER_SEC);
                end
                entry_mode  <= ttlog_pkg::MODE_NONE;
                digit_value <= '0;
                digit_count <= '0;
              end
              ttlog_pkg::CMD_DUMP: begin
                if (fill_count != '0) begin
                  idx   <= '0;
                  state <= ST_DUMP_RD;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_CONV_A: begin
          state <= ST_CONV_B;
        end
        ST_CONV_B: begin
          fill_count <= fill_count + CW'(1);
          state      <= ST_IDLE;
        end
        ST_COMMIT: begin
          // Read one entry per cycle, write it back the cycle after
          if (idx < fill_count) begin
            idx     <= idx_inc;
            rd_pend <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
            if (!rd_pend) begin
              state <= ST_IDLE;
            end
          end
        end
        ST_DUMP_RD: begin
          state <= ST_DUMP_LD;
        end
        ST_DUMP_LD: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            kind          <= ttlog_pkg::KIND_ENTRY;
            echo_byte     <= '0;
            entry_seconds <= ram_rdata.seconds;
            entry_temp    <= ram_rdata.temp;
            last          <= (idx_inc == fill_count);
            if (idx_inc == fill_count) begin
              fill_count <= '0;
              state      <= ST_IDLE;
            end else begin
              idx   <= idx_inc;
              state <= ST_DUMP_RD;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Checks
  `ASSERT_ALWAYS(a_fill_bound, fill_count <= FULL, "log fill count above depth")
  `ASSERT_ALWAYS(a_digit_bound, digit_count <= DIGIT_LIMIT, "digit count above limit")
  `ASSERT_ALWAYS(a_write_state, !ram_we || state == ST_CONV_B || state == ST_COMMIT,
    "log write outside sample or clock shift")
  `ASSERT_NEXT(a_dump_start,
    in_accept && command == ttlog_pkg::CMD_DUMP && fill_count != '0,
    state == ST_DUMP_RD, "dump of a filled log did not start")
  `ASSERT_NEXT(a_dump_empty, state == ST_DUMP_LD && out_free && idx_inc == fill_count,
    fill_count == '0 && out_valid && last, "dump did not end with last entry and empty log")

endmodule

`default_nettype wire

@@ tb/tb_timestamped_temperature_logger_top.sv @@
`timescale 1ns / 100ps

module tb_timestamped_temperature_logger_top;

  localparam int LOG_DEPTH     = 64;
  localparam int MAX_DIGITS    = 10;
  localparam int N_ITEMS       = 370;
  localparam int QUIET_ITEMS   = 40;
  localparam int PRESSURE_AT   = 150;
  localparam int PRESSURE_HOLD = 300;
  localparam int DRAIN_CYCLES  = 100;
  localparam int STALL_LIMIT   = 2000;

  typedef struct packed {
    logic              kind;
    logic [7:0]        echo;
    logic [31:0]       secs;
    logic signed [9:0] temp;
    logic              last;
  } log_out_t;

  typedef struct {
    logic [1:0] cmd;
    logic [9:0] sample;
    logic [7:0] rx;
    bit         typed;
    int         n_typed;
    log_out_t   typed_a;
    log_out_t   typed_b;
  } stim_t;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  logic [1:0]        command   = ttlog_pkg::CMD_TICK;
  logic [9:0]        sample    = '0;
  logic [7:0]        rx_byte   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              kind;
  logic [7:0]        echo_byte;
  logic [31:0]       entry_seconds;
  logic signed [9:0] entry_temp;
  logic              last;

  // Logger state as the predictor sees it
  logic signed [9:0] lg_temps [LOG_DEPTH];
  logic [31:0]       lg_times [LOG_DEPTH];
  int                lg_fill    = 0;
  logic [31:0]       lg_since   = '0;
  logic [63:0]       lg_uptime  = '0;
  logic [41:0]       lg_period  = ttlog_pkg::PERIOD_RESET;
  logic [31:0]       lg_digits  = '0;
  int                lg_ndigits = 0;
  logic [1:0]        lg_mode    = ttlog_pkg::MODE_NONE;

  stim_t    stim_q[$];
  log_out_t logger_out_q[$];
  int       err_count     = 0;
  int       sent_count    = 0;
  bit       quiet_phase   = 1'b0;
  bit       pressure_done = 1'b0;
  int       ready_hold    = 0;
  int       stall_cycles  = 0;

  timestamped_temperature_logger_top #(
    .LOG_DEPTH (LOG_DEPTH),
    .MAX_DIGITS(MAX_DIGITS)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .sample       (sample),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .echo_byte    (echo_byte),
    .entry_seconds(entry_seconds),
    .entry_temp   (entry_temp),
    .last         (last)
  );

  always #5 clk = ~clk;

  function automatic log_out_t echo_out(input logic [7:0] b);
    log_out_t r;
    r = '0;
    r.kind = ttlog_pkg::KIND_ECHO;
    r.echo = b;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic log_out_t entry_out(input logic [31:0] secs, input logic signed [9:0] temp,
                                         input logic lst);
    log_out_t r;
    r = '0;
    r.kind = ttlog_pkg::KIND_ENTRY;
    r.secs = secs;
    r.temp = temp;
    r.last = lst;
    return r;
  endfunction

  // Whole degrees, truncated toward zero
  function automatic logic signed [9:0] degrees_of(input logic [9:0] raw);
    int num;
    num = int'(raw) * 2500 - 254976;
    return 10'(num / 5120);
  endfunction

  // Idle only outside the quiet tail and outside every third stretch of items
  function automatic bit idle_allowed();
    return !quiet_phase && ((sent_count / 40) % 3 != 2);
  endfunction

  // Advance the logger state by one transaction; queue its results if asked
  task automatic apply_logger_item(input stim_t it, input bit push);
    logic [31:0] offset;
    logic [7:0]  d;
    int          i;
    case (it.cmd)
      ttlog_pkg::CMD_TICK: begin
        lg_since  = lg_since + 1;
        lg_uptime = lg_uptime + 1;
        if (lg_period <= 42'(lg_since)) begin
          lg_since = '0;
          if (lg_fill < LOG_DEPTH) begin
            lg_temps[lg_fill] = degrees_of(it.sample);
            lg_times[lg_fill] = 32'(lg_uptime / 1000);
            lg_fill++;
          end
        end
      end
      ttlog_pkg::CMD_BYTE: begin
        if (push) logger_out_q.push_back(echo_out(it.rx));
        if (it.rx == ttlog_pkg::CHAR_D) begin
          lg_mode = ttlog_pkg::MODE_PERIOD;
        end else if (it.rx == ttlog_pkg::CHAR_G) begin
          lg_mode = ttlog_pkg::MODE_CLOCK;
        end else if (it.rx != ttlog_pkg::CHAR_LF && it.rx != ttlog_pkg::CHAR_CR) begin
          d = it.rx - ttlog_pkg::CHAR_ZERO;
          if (lg_ndigits >= MAX_DIGITS) begin
            lg_digits  = '0;
            lg_ndigits = 0;
          end
          lg_digits = lg_digits * 10 + 32'(d);
          lg_ndigits++;
        end
      end
      ttlog_pkg::CMD_COMMIT: begin
        if (lg_mode == ttlog_pkg::MODE_CLOCK) begin
          offset = lg_digits - 32'(lg_uptime / 1000);
          for (i = 0; i < lg_fill; i++) begin
            if (lg_times[i] != 0) lg_times[i] = lg_times[i] + offset;
          end
          lg_uptime = 64'(lg_digits) * 1000;
        end else if (lg_mode == ttlog_pkg::MODE_PERIOD) begin
          lg_period = 42'(64'(lg_digits) * 1000);
        end
        lg_mode    = ttlog_pkg::MODE_NONE;
        lg_digits  = '0;
        lg_ndigits = 0;
      end
      default: begin
        for (i = 0; i < lg_fill; i++) begin
          if (push) logger_out_q.push_back(entry_out(lg_times[i], lg_temps[i], i == lg_fill - 1));
        end
        lg_fill = 0;
      end
    endcase
  endtask

  task automatic add_row(input logic [1:0] cmd, input logic [9:0] smp, input logic [7:0] rx,
                         input bit typed, input int n, input log_out_t a, input log_out_t b);
    stim_t s;
    s.cmd     = cmd;
    s.sample  = smp;
    s.rx      = rx;
    s.typed   = typed;
    s.n_typed = n;
    s.typed_a = a;
    s.typed_b = b;
    stim_q.push_back(s);
  endtask

  // Random sample on every item, so the unused fields toggle too
  task automatic add_item(input logic [1:0] cmd, input logic [7:0] rx);
    add_row(cmd, 10'($urandom_range(0, 1023)), rx, 1'b0, 0, '0, '0);
  endtask

  task automatic add_digits(input int k);
    int i;
    for (i = 0; i < k; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        add_item(ttlog_pkg::CMD_BYTE,
                 $urandom_range(0, 1) ? ttlog_pkg::CHAR_CR : ttlog_pkg::CHAR_LF);
      end
      add_item(ttlog_pkg::CMD_BYTE, ttlog_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
    end
  endtask

  task automatic add_rand_cmd(input logic [1:0] cmd);
    add_item(cmd, 8'($urandom_range(0, 255)));
  endtask

  // Compare one field and report a mismatch
  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Stimulus, reset and the send side
  initial begin
    int    gap;
    int    sel;
    int    k;
    int    j;
    string max_val;
    max_val = "4294967295";

    // Directed table: typed results where they are obvious, predictor elsewhere
    add_row(ttlog_pkg::CMD_DUMP,   10'h000, 8'h00, 1'b1, 0, '0, '0);
    add_row(ttlog_pkg::CMD_BYTE,   10'h000, ttlog_pkg::CHAR_D, 1'b1, 1,
            echo_out(ttlog_pkg::CHAR_D), '0);
    add_row(ttlog_pkg::CMD_COMMIT, 10'h3FF, 8'hFF, 1'b1, 0, '0, '0);
    add_row(ttlog_pkg::CMD_TICK,   10'h000, 8'h00, 1'b1, 0, '0, '0);
    add_row(ttlog_pkg::CMD_TICK,   10'h3FF, 8'hFF, 1'b1, 0, '0, '0);
    add_row(ttlog_pkg::CMD_DUMP,   10'h000, 8'h00, 1'b1, 2, entry_out(32'd0, -10'sd49, 1'b0),
            entry_out(32'd0, 10'sd449, 1'b1));
    add_row(ttlog_pkg::CMD_TICK,   10'h2AA, 8'h55, 1'b0, 0, '0, '0);
    add_row(ttlog_pkg::CMD_BYTE,   10'h000, ttlog_pkg::CHAR_G, 1'b1, 1,
            echo_out(ttlog_pkg::CHAR_G), '0);
    add_row(ttlog_pkg::CMD_BYTE,   10'h000, ttlog_pkg::CHAR_ZERO + 8'd4, 1'b1, 1,
            echo_out(ttlog_pkg::CHAR_ZERO + 8'd4), '0);
    add_row(ttlog_pkg::CMD_BYTE,   10'h000, ttlog_pkg::CHAR_ZERO + 8'd2, 1'b1, 1,
            echo_out(ttlog_pkg::CHAR_ZERO + 8'd2), '0);
    add_row(ttlog_pkg::CMD_BYTE,   10'h000, ttlog_pkg::CHAR_CR, 1'b1, 1,
            echo_out(ttlog_pkg::CHAR_CR), '0);
    add_row(ttlog_pkg::CMD_BYTE,   10'h000, ttlog_pkg::CHAR_LF, 1'b1, 1,
            echo_out(ttlog_pkg::CHAR_LF), '0);
    add_row(ttlog_pkg::CMD_COMMIT, 10'h000, 8'h00, 1'b1, 0, '0, '0);
    add_row(ttlog_pkg::CMD_TICK,   10'h155, 8'hAA, 1'b0, 0, '0, '0);
    add_row(ttlog_pkg::CMD_BYTE,   10'h000, ttlog_pkg::CHAR_G, 1'b1, 1,
            echo_out(ttlog_pkg::CHAR_G), '0);
    add_row(ttlog_pkg::CMD_BYTE,   10'h000, 8'hFF, 1'b1, 1, echo_out(8'hFF), '0);
    add_row(ttlog_pkg::CMD_BYTE,   10'h000, 8'h00, 1'b1, 1, echo_out(8'h00), '0);
    add_row(ttlog_pkg::CMD_COMMIT, 10'h000, 8'h00, 1'b0, 0, '0, '0);
    add_row(ttlog_pkg::CMD_BYTE,   10'h000, 8'h78, 1'b1, 1, echo_out(8'h78), '0);
    add_row(ttlog_pkg::CMD_COMMIT, 10'h000, 8'h00, 1'b0, 0, '0, '0);
    add_row(ttlog_pkg::CMD_TICK,   10'h3FF, 8'h00, 1'b0, 0, '0, '0);
    add_row(ttlog_pkg::CMD_DUMP,   10'h000, 8'h00, 1'b0, 0, '0, '0);

    // Fill the log past its depth with period zero, then empty it
    add_item(ttlog_pkg::CMD_BYTE, ttlog_pkg::CHAR_D);
    add_rand_cmd(ttlog_pkg::CMD_COMMIT);
    repeat (LOG_DEPTH + 6) add_rand_cmd(ttlog_pkg::CMD_TICK);
    add_rand_cmd(ttlog_pkg::CMD_DUMP);

    // Random sequences, mostly well formed
    while (stim_q.size() < N_ITEMS) begin
      sel = $urandom_range(0, 99);
      if (sel < 20) begin
        // period entry, biased to zero so ticks keep logging
        add_item(ttlog_pkg::CMD_BYTE, ttlog_pkg::CHAR_D);
        k = $urandom_range(0, 19);
        if (k >= 15) add_digits($urandom_range(1, 12));
        else if (k >= 12) add_item(ttlog_pkg::CMD_BYTE, ttlog_pkg::CHAR_ZERO);
        add_rand_cmd(ttlog_pkg::CMD_COMMIT);
      end else if (sel < 35) begin
        // clock entry
        add_item(ttlog_pkg::CMD_BYTE, ttlog_pkg::CHAR_G);
        if ($urandom_range(0, 9) == 0) begin
          for (j = 0; j < max_val.len(); j++) add_item(ttlog_pkg::CMD_BYTE, max_val[j]);
        end else begin
          add_digits($urandom_range(1, 11));
        end
        add_rand_cmd(ttlog_pkg::CMD_COMMIT);
      end else if (sel < 65) begin
        repeat ($urandom_range(1, 24)) add_rand_cmd(ttlog_pkg::CMD_TICK);
      end else if (sel < 75) begin
        add_rand_cmd(ttlog_pkg::CMD_DUMP);
      end else if (sel < 85) begin
        // broken entry: mode, digits, then no commit
        add_item(ttlog_pkg::CMD_BYTE,
                 $urandom_range(0, 1) ? ttlog_pkg::CHAR_D : ttlog_pkg::CHAR_G);
        add_digits($urandom_range(0, 4));
        add_rand_cmd($urandom_range(0, 1) ? ttlog_pkg::CMD_DUMP : ttlog_pkg::CMD_TICK);
      end else begin
        add_rand_cmd(2'($urandom_range(0, 3)));
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Send each transaction; predict at acceptance
    foreach (stim_q[i]) begin
      quiet_phase = (i >= stim_q.size() - QUIET_ITEMS);
      if (idle_allowed() && $urandom_range(0, 3) == 0) begin
        in_valid <= 1'b0;
        gap = $urandom_range(1, 9);
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      command  <= stim_q[i].cmd;
      sample   <= stim_q[i].sample;
      rx_byte  <= stim_q[i].rx;
      do @(posedge clk); while (!in_ready);
      sent_count++;
      apply_logger_item(stim_q[i], !stim_q[i].typed);
      if (stim_q[i].n_typed >= 1) logger_out_q.push_back(stim_q[i].typed_a);
      if (stim_q[i].n_typed >= 2) logger_out_q.push_back(stim_q[i].typed_b);
    end
    in_valid <= 1'b0;

    // Drain, then let any late commit walk finish
    while (logger_out_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Receive side: check each result, stall in bursts, one long hold-off
  initial begin
    log_out_t want;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (logger_out_q.size() == 0) begin
          err_count++;
          $display("%0t: result with none expected, actual kind %0h echo %0h seconds %0h temp %0h",
                   $time, kind, echo_byte, entry_seconds, entry_temp);
        end else begin
          want = logger_out_q.pop_front();
          check_field("kind", 32'(want.kind), 32'(kind));
          check_field("echo_byte", 32'(want.echo), 32'(echo_byte));
          check_field("entry_seconds", want.secs, entry_seconds);
          check_field("entry_temp", 32'(want.temp), 32'(entry_temp));
          check_field("last", 32'(want.last), 32'(last));
        end
      end
      if (ready_hold > 0) begin
        ready_hold--;
      end else if (!pressure_done && sent_count >= PRESSURE_AT) begin
        ready_hold    = PRESSURE_HOLD;
        pressure_done = 1'b1;
      end else if (idle_allowed() && $urandom_range(0, 5) == 0) begin
        ready_hold = $urandom_range(1, 9);
      end
      out_ready <= (ready_hold == 0);
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule
